### sv/hdcnb_pkg.sv
package hdcnb_pkg;

	localparam int WORD_COUNT   = 32;
	localparam int SYMBOL_COUNT = 27;
	localparam int MAX_NGRAM    = 8;
	localparam int COUNT_WIDTH  = 16;

	localparam int WORD_W     = 32;
	localparam int SYM_W      = 5;
	localparam int NGL_W      = 4;
	localparam int OUT_IDX_W  = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam int MEM_DEPTH = SYMBOL_COUNT * WORD_COUNT;
	localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int WIDX_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int FILL_W    = $clog2(MAX_NGRAM + 1);
	localparam int WIN_AW    = (MAX_NGRAM > 1) ? $clog2(MAX_NGRAM) : 1;

	localparam logic [CFG_IDX_W-1:0] CFG_NGRAM_LENGTH    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_TIEBREAK_SYMBOL = CFG_IDX_W'(1);

	localparam logic [NGL_W-1:0] NGL_RESET = NGL_W'(3);
	localparam logic [SYM_W-1:0] TBS_RESET = SYM_W'(26);

	// xorshift128 generator
	localparam logic [WORD_W-1:0] XS_SEED_X = 32'd123456789;
	localparam logic [WORD_W-1:0] XS_SEED_Y = 32'd362436069;
	localparam logic [WORD_W-1:0] XS_SEED_Z = 32'd521288629;
	localparam logic [WORD_W-1:0] XS_SEED_W = 32'd88675123;
	localparam int XS_SHL_T = 11;
	localparam int XS_SHR_W = 19;
	localparam int XS_SHR_T = 8;

	typedef struct packed {
		logic              shift;
		logic              fire;
		logic              count;
		logic [WIN_AW-1:0] rot;
		logic              maj;
	} cell_cmd_t;

endpackage

### sv/hdcnb_if.sv
interface hdcnb_text_if;
	logic                        valid;
	logic                        ready;
	logic [hdcnb_pkg::SYM_W-1:0] symbol;
	logic                        text_end;

	modport source (output valid, symbol, text_end, input ready);
	modport sink (input valid, symbol, text_end, output ready);
endinterface

interface hdcnb_result_if;
	logic                             valid;
	logic                             ready;
	logic [hdcnb_pkg::OUT_IDX_W-1:0] word_index;
	logic [hdcnb_pkg::WORD_W-1:0]    word_value;
	logic                             overflow;
	logic                             last_word;

	modport source (output valid, word_index, word_value, overflow, last_word, input ready);
	modport sink (input valid, word_index, word_value, overflow, last_word, output ready);
endinterface

interface hdcnb_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [hdcnb_pkg::CFG_IDX_W-1:0]  index;
	logic [hdcnb_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/hdcnb_item_mem.sv
module hdcnb_item_mem (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [hdcnb_pkg::MEM_AW-1:0]   rd_addr,
	output logic [hdcnb_pkg::WORD_W-1:0]   rd_data,
	output logic                            mem_ready
);

	logic [hdcnb_pkg::WORD_W-1:0] mem [hdcnb_pkg::MEM_DEPTH];
	logic [hdcnb_pkg::WORD_W-1:0] x_q, y_q, z_q, w_q;
	logic [hdcnb_pkg::WORD_W-1:0] t_w, w_next;
	logic [hdcnb_pkg::MEM_AW-1:0] fill_a_q;
	logic                          busy_q;
	logic [hdcnb_pkg::WORD_W-1:0] rd_q;

	assign t_w    = x_q ^ (x_q << hdcnb_pkg::XS_SHL_T);
	assign w_next = (w_q ^ (w_q >> hdcnb_pkg::XS_SHR_W)) ^ (t_w ^ (t_w >> hdcnb_pkg::XS_SHR_T));

	// fill: entry a gets the generator word after a steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q      <= hdcnb_pkg::XS_SEED_X;
			y_q      <= hdcnb_pkg::XS_SEED_Y;
			z_q      <= hdcnb_pkg::XS_SEED_Z;
			w_q      <= hdcnb_pkg::XS_SEED_W;
			fill_a_q <= '0;
			busy_q   <= 1'b1;
		end else if (busy_q) begin
			x_q <= y_q;
			y_q <= z_q;
			z_q <= w_q;
			w_q <= w_next;
			if (fill_a_q == hdcnb_pkg::MEM_AW'(hdcnb_pkg::MEM_DEPTH - 1)) begin
				busy_q <= 1'b0;
			end else begin
				fill_a_q <= fill_a_q + hdcnb_pkg::MEM_AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[fill_a_q] <= w_q;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data   = rd_q;
	assign mem_ready = !busy_q;

endmodule

### sv/hdcnb_cell.sv
module hdcnb_cell (
	input  logic                                clk,
	input  logic                                arst_n,
	input  hdcnb_pkg::cell_cmd_t                cmd,
	input  logic [hdcnb_pkg::COUNT_WIDTH-1:0]  half_total,
	input  logic [hdcnb_pkg::WORD_W-1:0]       shift_in,
	input  logic [hdcnb_pkg::WORD_W-1:0]       ring_nb,
	output logic [hdcnb_pkg::WORD_W-1:0]       word,
	output logic                                sat
);

	logic [hdcnb_pkg::WORD_W-1:0]      word_q, acc_q, rot_w, vote_w, maj_w;
	logic [2*hdcnb_pkg::WORD_W-1:0]    pair_w;
	logic [hdcnb_pkg::COUNT_WIDTH-1:0] cnt_q [hdcnb_pkg::WORD_W];
	logic                               sat_q;

	// rotate right across the word boundary into the next cell's word
	assign pair_w = {ring_nb, word_q} >> cmd.rot;
	assign rot_w  = pair_w[hdcnb_pkg::WORD_W-1:0];
	assign vote_w = acc_q ^ rot_w;

	always_comb begin
		for (int i = 0; i < hdcnb_pkg::WORD_W; i++) begin
			maj_w[i] = (cnt_q[i] > half_total);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.maj) begin
			word_q <= maj_w;
		end else if (cmd.shift) begin
			word_q <= shift_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.fire) begin
			acc_q <= cmd.count ? '0 : vote_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hdcnb_pkg::WORD_W; i++) begin
				cnt_q[i] <= '0;
			end
			sat_q <= 1'b0;
		end else if (cmd.maj) begin
			for (int i = 0; i < hdcnb_pkg::WORD_W; i++) begin
				cnt_q[i] <= '0;
			end
			sat_q <= 1'b0;
		end else if (cmd.fire && cmd.count) begin
			for (int i = 0; i < hdcnb_pkg::WORD_W; i++) begin
				if (vote_w[i]) begin
					if (cnt_q[i] == '1) begin
						sat_q <= 1'b1;
					end else begin
						cnt_q[i] <= cnt_q[i] + hdcnb_pkg::COUNT_WIDTH'(1);
					end
				end
			end
		end
	end

	assign word = word_q;
	assign sat  = sat_q;

endmodule

### sv/hdc_ngram_encode_bundle_core.sv
// channel | dir | word                                        | accepted when
// text    | in  | symbol, text_end                            | text.valid & text.ready
// result  | out | word_index, word_value, overflow, last_word | result.valid & result.ready
// cfg     | in  | index, data                                 | cfg.valid & cfg.ready
//
// After reset a generator sweep fills all 864 item memory entries; text.ready stays low.
// A symbol that completes a window streams n*WORD_COUNT item words (n = n-gram length): the
// single item memory read port streams one word per cycle into the cell chain. At text end a
// tie-break vector is fed when the n-gram count is even, then the majority is taken, then
// WORD_COUNT result words follow, one per cycle while result.ready.
// No text word is taken until the last result word has gone.
module hdc_ngram_encode_bundle_core (
	input logic            clk,
	input logic            arst_n,
	hdcnb_text_if.sink     text,
	hdcnb_result_if.source result,
	hdcnb_cfg_if.sink      cfg
);

	typedef enum logic [5:0] {
		S_INIT = 6'b000001,
		S_IDLE = 6'b000010,
		S_FEED = 6'b000100,
		S_WAIT = 6'b001000,
		S_MAJ  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t                            state_q;
	logic [hdcnb_pkg::NGL_W-1:0]       ngl_q;
	logic [hdcnb_pkg::SYM_W-1:0]       tbs_q;
	logic [hdcnb_pkg::SYM_W-1:0]       win_q [hdcnb_pkg::MAX_NGRAM];
	logic [hdcnb_pkg::FILL_W-1:0]      fill_q, n_q, fill_next, n_eff;
	logic [hdcnb_pkg::WIN_AW-1:0]      j_q;
	logic [hdcnb_pkg::WIDX_W-1:0]      w_q, oi_q;
	logic                               end_q, tb_q, ovf_q;
	logic [hdcnb_pkg::COUNT_WIDTH-1:0] total_q;
	logic                               tot_sat_q;

	logic                               vld_s1, zero_s1, lastw_s1, lastv_s1;
	logic [hdcnb_pkg::WIN_AW-1:0]      rot_s1, rot_s2;
	logic                               fire_s2, count_s2;

	logic                               text_acc, res_acc, cfg_acc;
	logic [hdcnb_pkg::SYM_W-1:0]       sym_sel;
	logic                               sym_ok, feed_lastw, feed_lastv, pipe_idle, mem_ready;
	logic [hdcnb_pkg::MEM_AW-1:0]      rd_addr;
	logic [hdcnb_pkg::WORD_W-1:0]      rd_data, word_in;
	logic [hdcnb_pkg::WORD_W-1:0]      cell_word [hdcnb_pkg::WORD_COUNT];
	logic [hdcnb_pkg::WORD_W-1:0]      chain_in [hdcnb_pkg::WORD_COUNT];
	logic [hdcnb_pkg::WORD_COUNT-1:0]  cell_sat;
	hdcnb_pkg::cell_cmd_t              cmd;

	assign text_acc = text.valid && text.ready;
	assign res_acc  = result.valid && result.ready;
	assign cfg_acc  = cfg.valid && cfg.ready;

	assign text.ready = (state_q == S_IDLE);
	assign cfg.ready  = 1'b1;

	assign fill_next = (fill_q == hdcnb_pkg::FILL_W'(hdcnb_pkg::MAX_NGRAM)) ? fill_q :
		fill_q + hdcnb_pkg::FILL_W'(1);
	assign n_eff = (ngl_q == '0) ? hdcnb_pkg::FILL_W'(1) :
		(int'(ngl_q) > hdcnb_pkg::MAX_NGRAM) ? hdcnb_pkg::FILL_W'(hdcnb_pkg::MAX_NGRAM) :
		hdcnb_pkg::FILL_W'(ngl_q);

	// oldest window symbol first
	assign sym_sel = tb_q ? tbs_q :
		win_q[hdcnb_pkg::WIN_AW'(n_q - hdcnb_pkg::FILL_W'(1) - hdcnb_pkg::FILL_W'(j_q))];
	assign sym_ok  = int'(sym_sel) < hdcnb_pkg::SYMBOL_COUNT;
	assign rd_addr = sym_ok ?
		hdcnb_pkg::MEM_AW'(int'(sym_sel) * hdcnb_pkg::WORD_COUNT + int'(w_q)) : '0;

	assign feed_lastw = (w_q == hdcnb_pkg::WIDX_W'(hdcnb_pkg::WORD_COUNT - 1));
	assign feed_lastv = tb_q || (hdcnb_pkg::FILL_W'(j_q) == n_q - hdcnb_pkg::FILL_W'(1));
	assign pipe_idle  = !vld_s1 && !fire_s2;

	assign word_in = zero_s1 ? '0 : rd_data;

	assign cmd.shift = vld_s1 || res_acc;
	assign cmd.fire  = fire_s2;
	assign cmd.count = count_s2;
	assign cmd.rot   = rot_s2;
	assign cmd.maj   = (state_q == S_MAJ);

	hdcnb_item_mem u_item_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (state_q == S_FEED),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.mem_ready (mem_ready)
	);

	for (genvar g = 0; g < hdcnb_pkg::WORD_COUNT; g++) begin : g_cell
		localparam int NB = (g + 1) % hdcnb_pkg::WORD_COUNT;

		assign chain_in[g] = (g == hdcnb_pkg::WORD_COUNT - 1) ? word_in : cell_word[NB];

		hdcnb_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.half_total (total_q >> 1),
			.shift_in   (chain_in[g]),
			.ring_nb    (cell_word[NB]),
			.word       (cell_word[g]),
			.sat        (cell_sat[g])
		);
	end

	assign result.valid      = (state_q == S_OUT);
	assign result.word_value = cell_word[0];
	assign result.word_index = hdcnb_pkg::OUT_IDX_W'(oi_q);
	assign result.overflow   = ovf_q;
	assign result.last_word  = (oi_q == hdcnb_pkg::WIDX_W'(hdcnb_pkg::WORD_COUNT - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ngl_q <= hdcnb_pkg::NGL_RESET;
			tbs_q <= hdcnb_pkg::TBS_RESET;
		end else if (cfg_acc) begin
			priority if (cfg.index == hdcnb_pkg::CFG_NGRAM_LENGTH) begin
				ngl_q <= cfg.data[hdcnb_pkg::NGL_W-1:0];
			end else if (cfg.index == hdcnb_pkg::CFG_TIEBREAK_SYMBOL) begin
				tbs_q <= cfg.data[hdcnb_pkg::SYM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		zero_s1  <= !sym_ok;
		lastw_s1 <= feed_lastw;
		lastv_s1 <= feed_lastv;
		rot_s1   <= tb_q ? '0 : j_q;
		rot_s2   <= rot_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			fire_s2  <= 1'b0;
			count_s2 <= 1'b0;
		end else begin
			vld_s1   <= (state_q == S_FEED);
			fire_s2  <= vld_s1 && lastw_s1;
			count_s2 <= vld_s1 && lastw_s1 && lastv_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_INIT;
			for (int i = 0; i < hdcnb_pkg::MAX_NGRAM; i++) begin
				win_q[i] <= '0;
			end
			fill_q    <= '0;
			n_q       <= hdcnb_pkg::FILL_W'(1);
			j_q       <= '0;
			w_q       <= '0;
			oi_q      <= '0;
			end_q     <= 1'b0;
			tb_q      <= 1'b0;
			ovf_q     <= 1'b0;
			total_q   <= '0;
			tot_sat_q <= 1'b0;
		end else begin
			if (fire_s2 && count_s2) begin
				if (total_q == '1) begin
					tot_sat_q <= 1'b1;
				end else begin
					total_q <= total_q + hdcnb_pkg::COUNT_WIDTH'(1);
				end
			end
			unique case (state_q)
				S_INIT: begin
					if (mem_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (text_acc) begin
						for (int i = hdcnb_pkg::MAX_NGRAM - 1; i > 0; i--) begin
							win_q[i] <= win_q[i-1];
						end
						win_q[0] <= text.symbol;
						fill_q   <= fill_next;
						end_q    <= text.text_end;
						n_q      <= n_eff;
						j_q      <= '0;
						w_q      <= '0;
						tb_q     <= 1'b0;
						if (fill_next >= n_eff) begin
							state_q <= S_FEED;
						end else if (text.text_end) begin
							state_q <= S_WAIT;
						end
					end
				end
				S_FEED: begin
					if (feed_lastw) begin
						w_q <= '0;
						j_q <= j_q + hdcnb_pkg::WIN_AW'(1);
						if (feed_lastv) begin
							state_q <= S_WAIT;
						end
					end else begin
						w_q <= w_q + hdcnb_pkg::WIDX_W'(1);
					end
				end
				S_WAIT: begin
					if (pipe_idle) begin
						priority if (!end_q) begin
							state_q <= S_IDLE;
						end else if (!tb_q && !total_q[0]) begin
							tb_q    <= 1'b1;
							j_q     <= '0;
							w_q     <= '0;
							state_q <= S_FEED;
						end else begin
							state_q <= S_MAJ;
						end
					end
				end
				S_MAJ: begin
					ovf_q     <= tot_sat_q || (|cell_sat);
					total_q   <= '0;
					tot_sat_q <= 1'b0;
					for (int i = 0; i < hdcnb_pkg::MAX_NGRAM; i++) begin
						win_q[i] <= '0;
					end
					fill_q    <= '0;
					end_q     <= 1'b0;
					tb_q      <= 1'b0;
					oi_q      <= '0;
					state_q   <= S_OUT;
				end
				S_OUT: begin
					if (res_acc) begin
						oi_q <= oi_q + hdcnb_pkg::WIDX_W'(1);
						if (result.last_word) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_text_pipe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		text_acc |-> (!vld_s1 && !fire_s2))
		else $error("text word taken while the cell chain is busy");

	a_out_no_feed: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (!vld_s1 && !fire_s2))
		else $error("item memory feeding during result run");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_acc && result.last_word) |=> text.ready)
		else $error("not ready for text after last result word");

	a_total_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAJ) |=> (total_q == '0 && !tot_sat_q && fill_q == '0))
		else $error("text state not cleared after majority");
`endif

endmodule

### test/hdcnb_majority_checker.sv
module hdcnb_majority_checker (
	input logic     clk,
	input logic     arst_n,
	hdcnb_text_if   text,
	hdcnb_result_if result,
	hdcnb_cfg_if    cfg,
	output int      words_due,
	output int      fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import hdcnb_pkg::*;

	localparam int HV_BITS    = WORD_COUNT * WORD_W;
	localparam int COUNT_MAX  = (1 << COUNT_WIDTH) - 1;

	typedef logic [HV_BITS-1:0] hypervec_t;

	typedef struct packed {
		logic [OUT_IDX_W-1:0] word_no;
		logic [WORD_W-1:0]    bits;
		logic                 overflow;
		logic                 last;
	} bundle_word_t;

	hypervec_t        item_hv [SYMBOL_COUNT];
	logic [SYM_W-1:0] window [MAX_NGRAM];
	int               fill;
	int               counts [HV_BITS];
	int               grams;
	logic             saturated;
	logic [NGL_W-1:0] ngram_len;
	logic [SYM_W-1:0] tie_sym;
	bundle_word_t     words_q [$];
	int               mismatches = 0;

	assign fail_count = mismatches;

	initial begin
		logic [WORD_W-1:0] x, y, z, w, t, wd;
		x = XS_SEED_X;
		y = XS_SEED_Y;
		z = XS_SEED_Z;
		w = XS_SEED_W;
		for (int i = 0; i < MEM_DEPTH; i++) begin
			if (i == 0) begin
				wd = XS_SEED_W;
			end else begin
				t = x ^ (x << XS_SHL_T);
				x = y;
				y = z;
				z = w;
				w = (w ^ (w >> XS_SHR_W)) ^ (t ^ (t >> XS_SHR_T));
				wd = w;
			end
			item_hv[i / WORD_COUNT][(i % WORD_COUNT) * WORD_W +: WORD_W] = wd;
		end
	end

	function automatic hypervec_t item_vector(input logic [SYM_W-1:0] sym);
		if (sym >= SYMBOL_COUNT) return '0;
		return item_hv[sym];
	endfunction

	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		mismatches++;
		$display("%0t mismatch on %s: got %h, want %h", $realtime, what, got, want);
	endtask

	task automatic clear_text();
		for (int i = 0; i < MAX_NGRAM; i++) window[i] = '0;
		for (int b = 0; b < HV_BITS; b++) counts[b] = 0;
		fill = 0;
		grams = 0;
		saturated = 1'b0;
	endtask

	// saturating per-bit vote plus one n-gram
	task automatic accumulate(input hypervec_t hv);
		for (int b = 0; b < HV_BITS; b++) begin
			if (hv[b]) begin
				if (counts[b] >= COUNT_MAX) saturated = 1'b1;
				else counts[b]++;
			end
		end
		if (grams >= COUNT_MAX) saturated = 1'b1;
		else grams++;
	endtask

	task automatic absorb_symbol(input logic [SYM_W-1:0] sym, input logic closes);
		int           n;
		hypervec_t    hv;
		hypervec_t    gram;
		bundle_word_t bw;
		n = (ngram_len == 0) ? 1 : (ngram_len > MAX_NGRAM) ? MAX_NGRAM : int'(ngram_len);
		for (int i = MAX_NGRAM - 1; i > 0; i--) window[i] = window[i - 1];
		window[0] = sym;
		if (fill < MAX_NGRAM) fill++;
		if (fill >= n) begin
			gram = '0;
			// oldest symbol unrotated, each newer one rotated right by one more bit
			for (int j = 0; j < n; j++) begin
				hv = item_vector(window[n - 1 - j]);
				gram ^= (hv >> j) | (hv << (HV_BITS - j));
			end
			accumulate(gram);
		end
		if (!closes) return;
		if (!grams[0]) accumulate(item_vector(tie_sym));
		for (int wd = 0; wd < WORD_COUNT; wd++) begin
			bw.word_no  = OUT_IDX_W'(wd);
			bw.overflow = saturated;
			bw.last     = (wd == WORD_COUNT - 1);
			for (int k = 0; k < WORD_W; k++)
				bw.bits[k] = counts[wd * WORD_W + k] > grams / 2;
			words_q.push_back(bw);
		end
		clear_text();
	endtask

	always @(posedge clk or negedge arst_n) begin
		bundle_word_t want;
		if (!arst_n) begin
			clear_text();
			ngram_len = NGL_RESET;
			tie_sym   = TBS_RESET;
			words_q.delete();
			words_due <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_NGRAM_LENGTH) ngram_len = cfg.data[NGL_W-1:0];
				else if (cfg.index == CFG_TIEBREAK_SYMBOL) tie_sym = cfg.data[SYM_W-1:0];
			end
			if (result.valid && result.ready) begin
				if (words_q.size() == 0) begin
					report_mismatch("word with none due", result.word_value, '0);
				end else begin
					want = words_q.pop_front();
					if (result.word_index !== want.word_no)
						report_mismatch("word_index", WORD_W'(result.word_index),
							WORD_W'(want.word_no));
					if (result.word_value !== want.bits)
						report_mismatch("word_value", result.word_value, want.bits);
					if (result.overflow !== want.overflow)
						report_mismatch("overflow", WORD_W'(result.overflow),
							WORD_W'(want.overflow));
					if (result.last_word !== want.last)
						report_mismatch("last_word", WORD_W'(result.last_word),
							WORD_W'(want.last));
				end
			end
			if (text.valid && text.ready) absorb_symbol(text.symbol, text.text_end);
			words_due <= words_q.size();
		end
	end

endmodule

### test/tb_hdc_ngram_encode_bundle_core.sv
module tb_hdc_ngram_encode_bundle_core;
	timeunit 1ns;
	timeprecision 1ps;

	import hdcnb_pkg::*;

	localparam int     HALF_PERIOD    = 10;
	localparam int     PHASES         = 8;
	localparam int     PHASE_ITEMS    = 56;
	localparam int     PRESSURE_PHASE = 4;
	localparam int     IDLE_GAP       = 400;
	localparam int     HOLD_CYCLES    = 600;
	localparam longint CYCLE_LIMIT    = 1_500_000;

	logic   clk = 1'b0;
	logic   arst_n;
	int     words_due;
	int     fail_count;
	int     gap_pct = 0;
	int     stall_pct = 0;
	int     pressure_reqs = 0;
	int     pressure_done = 0;
	int     symbols_sent = 0;
	int     texts_closed = 0;
	int     open_left = 0;
	longint cycles = 0;

	hdcnb_text_if   text_ch ();
	hdcnb_result_if result_ch ();
	hdcnb_cfg_if    cfg_ch ();

	hdc_ngram_encode_bundle_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	hdcnb_majority_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text_ch),
		.result     (result_ch),
		.cfg        (cfg_ch),
		.words_due  (words_due),
		.fail_count (fail_count)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still due", cycles, words_due);
			$display("simulation failed");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int hold;
		hold = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (pressure_done != pressure_reqs) begin
				pressure_done++;
				hold = HOLD_CYCLES;
			end
			if (hold > 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic closes);
		while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid    <= 1'b1;
		text_ch.symbol   <= sym;
		text_ch.text_end <= closes;
		do @(posedge clk); while (text_ch.ready !== 1'b1);
		symbols_sent++;
		if (closes) texts_closed++;
	endtask

	task automatic send_text(input int syms[$], input logic closes);
		foreach (syms[i])
			send_symbol(SYM_W'(syms[i]), closes && (i == syms.size() - 1));
	endtask

	task automatic load_regs(input logic [CFG_DATA_W-1:0] len_data,
			input logic [CFG_DATA_W-1:0] tie_data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= CFG_NGRAM_LENGTH;
		cfg_ch.data  <= len_data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.index <= CFG_TIEBREAK_SYMBOL;
		cfg_ch.data  <= tie_data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
	endtask

	// drain all due words, then let any window still in flight finish
	task automatic settle();
		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (words_due != 0) @(posedge clk);
		repeat (IDLE_GAP) @(posedge clk);
	endtask

	function automatic logic [SYM_W-1:0] pick_symbol();
		int r;
		r = $urandom_range(99);
		if (r < 5) return SYM_W'($urandom_range(SYMBOL_COUNT, 31));
		if (r < 10) return SYM_W'(SYMBOL_COUNT - 1);
		return SYM_W'($urandom_range(0, SYMBOL_COUNT - 2));
	endfunction

	function automatic int pick_text_len();
		int r;
		r = $urandom_range(99);
		if (r < 10) return 1;
		if (r < 85) return $urandom_range(2, 12);
		return $urandom_range(13, 40);
	endfunction

	initial begin
		int len_val;
		int tie_val;
		arst_n           <= 1'b0;
		text_ch.valid    <= 1'b0;
		text_ch.symbol   <= '0;
		text_ch.text_end <= 1'b0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.index     <= CFG_NGRAM_LENGTH;
		cfg_ch.data      <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset registers: length 3, tie-break 26
		send_text('{0}, 1'b1);
		send_text('{0, 26, 31, 1, 27}, 1'b1);
		send_text('{16, 8, 4, 2}, 1'b1);
		settle();
		load_regs(8'hF0, 8'hFF);
		send_text('{5, 9, 30, 3}, 1'b1);
		settle();
		load_regs(8'h5F, 8'hE0);
		send_text('{1, 2, 3, 4, 5, 6, 7, 8, 9}, 1'b1);
		send_text('{7, 11}, 1'b0);
		settle();
		load_regs(8'h01, 8'h00);
		send_text('{19}, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 59; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 59; end
				default: begin gap_pct = 35; stall_pct = 35; end
			endcase
			case (p)
				0: begin len_val = 1;  tie_val = 0;  end
				1: begin len_val = 8;  tie_val = 26; end
				2: begin len_val = 0;  tie_val = 31; end
				3: begin len_val = 15; tie_val = 25; end
				default: begin
					len_val = $urandom_range(0, 15);
					tie_val = $urandom_range(0, 31);
				end
			endcase
			load_regs({4'($urandom), 4'(len_val)}, {3'($urandom), 5'(tie_val)});
			if (p == PRESSURE_PHASE) begin
				pressure_reqs++;
				open_left = 0;
				send_symbol(pick_symbol(), 1'b1);
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (open_left == 0) open_left = pick_text_len();
				open_left--;
				send_symbol(pick_symbol(), open_left == 0);
			end
		end
		if (open_left != 0) send_symbol(pick_symbol(), 1'b1);
		settle();

		$display("%0d symbols in %0d texts (%0d words), %0d register phases",
			symbols_sent, texts_closed, texts_closed * WORD_COUNT, PHASES + 3);
		$display("lengths 0..15, in and out of range symbols, long result hold-off");
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
